[sv/qte_pkg.sv]
// Shared types, constants and the microcode program for the quad tank Euler step.
// Used by every module of the block; depends on nothing else.
package qte_pkg;

  localparam int LEVEL_W = 32;
  localparam int GAIN_W = 32;
  localparam int GAIN_FRAC_BITS = 24;
  localparam int VOLT_W = 16;
  localparam int VOLT_FRAC_BITS = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam int PC_W = 5;
  localparam int TANK_IDX_W = 2;
  localparam int NUM_TANKS = 4;
  localparam int LEVEL_FRAC_BITS_DEF = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DRAIN_1 = 3'd0,
    REG_DRAIN_2 = 3'd1,
    REG_DRAIN_3 = 3'd2,
    REG_DRAIN_4 = 3'd3,
    REG_CROSS_31 = 3'd4,
    REG_CROSS_42 = 3'd5,
    REG_PUMP_1 = 3'd6,
    REG_PUMP_2 = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_IN = 2'd1,
    COND_SQRT = 2'd2,
    COND_OUT = 2'd3
  } cond_t;

  typedef enum logic [3:0] {
    G_DRAIN_1 = 4'd0,
    G_DRAIN_2 = 4'd1,
    G_DRAIN_3 = 4'd2,
    G_DRAIN_4 = 4'd3,
    G_CROSS_31 = 4'd4,
    G_CROSS_42 = 4'd5,
    G_P1_LO = 4'd6,
    G_P1_HI = 4'd7,
    G_P2_LO = 4'd8,
    G_P2_HI = 4'd9
  } gain_sel_t;

  typedef enum logic [1:0] {
    B_ROOT = 2'd0,
    B_VOLT_1 = 2'd1,
    B_VOLT_2 = 2'd2
  } mulb_sel_t;

  typedef enum logic [2:0] {
    ACC_NONE = 3'd0,
    ACC_LOAD = 3'd1,
    ACC_ADD_ROOT = 3'd2,
    ACC_ADD_PUMP = 3'd3,
    ACC_SUB_ROOT = 3'd4,
    ACC_SETTLE = 3'd5
  } acc_op_t;

  typedef struct packed {
    cond_t cond;
    logic [PC_W-1:0] next;
    logic in_take;
    logic sqrt_start;
    logic root_wr;
    logic [TANK_IDX_W-1:0] tank;
    logic mul_en;
    gain_sel_t gain_sel;
    mulb_sel_t b_sel;
    logic [TANK_IDX_W-1:0] b_tank;
    acc_op_t acc_op;
    logic out_load;
  } ucode_t;

  typedef struct packed {
    logic fire;
    ucode_t uc;
  } ctl_t;

  typedef struct packed {
    logic sqrt_busy;
    logic out_busy;
  } stat_t;

  // The program. A step's actions take effect at the edge where its condition holds.
  function automatic ucode_t qte_ucode(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '0;
    w.next = pc + 1'b1;
    unique case (pc)
      5'd0: begin
        w.cond = COND_IN;
        w.in_take = 1'b1;
      end
      5'd1, 5'd3, 5'd5, 5'd7: begin
        w.sqrt_start = 1'b1;
        w.tank = pc[TANK_IDX_W:1];
      end
      5'd2, 5'd4, 5'd6, 5'd8: begin
        w.cond = COND_SQRT;
        w.root_wr = 1'b1;
        w.tank = pc[TANK_IDX_W:1] - 1'b1;
      end
      // Tank 1: level + cross(root 3) + pump 1 low - drain(root 1).
      5'd9: begin
        w.acc_op = ACC_LOAD;
        w.tank = 2'd0;
        w.mul_en = 1'b1;
        w.gain_sel = G_CROSS_31;
        w.b_sel = B_ROOT;
        w.b_tank = 2'd2;
      end
      5'd10: begin
        w.acc_op = ACC_ADD_ROOT;
        w.mul_en = 1'b1;
        w.gain_sel = G_P1_LO;
        w.b_sel = B_VOLT_1;
      end
      5'd11: begin
        w.acc_op = ACC_ADD_PUMP;
        w.mul_en = 1'b1;
        w.gain_sel = G_DRAIN_1;
        w.b_sel = B_ROOT;
        w.b_tank = 2'd0;
      end
      5'd12: w.acc_op = ACC_SUB_ROOT;
      5'd13: begin
        w.acc_op = ACC_SETTLE;
        w.tank = 2'd0;
      end
      // Tank 2: level + cross(root 4) + pump 2 low - drain(root 2).
      5'd14: begin
        w.acc_op = ACC_LOAD;
        w.tank = 2'd1;
        w.mul_en = 1'b1;
        w.gain_sel = G_CROSS_42;
        w.b_sel = B_ROOT;
        w.b_tank = 2'd3;
      end
      5'd15: begin
        w.acc_op = ACC_ADD_ROOT;
        w.mul_en = 1'b1;
        w.gain_sel = G_P2_LO;
        w.b_sel = B_VOLT_2;
      end
      5'd16: begin
        w.acc_op = ACC_ADD_PUMP;
        w.mul_en = 1'b1;
        w.gain_sel = G_DRAIN_2;
        w.b_sel = B_ROOT;
        w.b_tank = 2'd1;
      end
      5'd17: w.acc_op = ACC_SUB_ROOT;
      5'd18: begin
        w.acc_op = ACC_SETTLE;
        w.tank = 2'd1;
      end
      // Tank 3: level + pump 2 high - drain(root 3).
      5'd19: begin
        w.acc_op = ACC_LOAD;
        w.tank = 2'd2;
        w.mul_en = 1'b1;
        w.gain_sel = G_P2_HI;
        w.b_sel = B_VOLT_2;
      end
      5'd20: begin
        w.acc_op = ACC_ADD_PUMP;
        w.mul_en = 1'b1;
        w.gain_sel = G_DRAIN_3;
        w.b_sel = B_ROOT;
        w.b_tank = 2'd2;
      end
      5'd21: w.acc_op = ACC_SUB_ROOT;
      5'd22: begin
        w.acc_op = ACC_SETTLE;
        w.tank = 2'd2;
      end
      // Tank 4: level + pump 1 high - drain(root 4).
      5'd23: begin
        w.acc_op = ACC_LOAD;
        w.tank = 2'd3;
        w.mul_en = 1'b1;
        w.gain_sel = G_P1_HI;
        w.b_sel = B_VOLT_1;
      end
      5'd24: begin
        w.acc_op = ACC_ADD_PUMP;
        w.mul_en = 1'b1;
        w.gain_sel = G_DRAIN_4;
        w.b_sel = B_ROOT;
        w.b_tank = 2'd3;
      end
      5'd25: w.acc_op = ACC_SUB_ROOT;
      5'd26: begin
        w.acc_op = ACC_SETTLE;
        w.tank = 2'd3;
      end
      5'd27: begin
        w.cond = COND_OUT;
        w.out_load = 1'b1;
        w.next = '0;
      end
      default: w.next = '0;
    endcase
    return w;
  endfunction

endpackage

[sv/qte_sqrt.sv]
// Iterative floor square root of (level << LEVEL_FRAC_BITS), two root bits per cycle.
// Depends on qte_pkg.
module qte_sqrt #(
  parameter int LEVEL_FRAC_BITS = qte_pkg::LEVEL_FRAC_BITS_DEF,
  localparam int ITER = (qte_pkg::LEVEL_W + LEVEL_FRAC_BITS + 3) / 4,
  localparam int ROOT_W = 2 * ITER
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [qte_pkg::LEVEL_W-1:0] level,
  output logic busy,
  output logic [ROOT_W-1:0] root
);
  import qte_pkg::*;

  localparam int RAD_W = 4 * ITER;
  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = $clog2(ITER + 1);

  logic [RAD_W-1:0] rad;
  logic [REM_W-1:0] rem;
  logic [ROOT_W-1:0] q;
  logic [CNT_W-1:0] cnt;
  logic [RAD_W-1:0] rad_init;
  logic [REM_W-1:0] rem_v;
  logic [REM_W-1:0] rem_s;
  logic [REM_W-1:0] trial;
  logic [ROOT_W-1:0] q_v;

  assign rad_init = RAD_W'(level) << LEVEL_FRAC_BITS;
  assign root = q;

  // Restoring square root: the remainder stays below 2^ROOT_W before each shift,
  // so its two top bits can be dropped.
  always_comb begin
    rem_v = rem;
    q_v = q;
    rem_s = '0;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      rem_s = {rem_v[REM_W-3:0], rad[RAD_W-1-2*i -: 2]};
      trial = {q_v, 2'b01};
      if (rem_s >= trial) begin
        rem_v = rem_s - trial;
        q_v = {q_v[ROOT_W-2:0], 1'b1};
      end else begin
        rem_v = rem_s;
        q_v = {q_v[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNT_W'(ITER);
      rad <= rad_init;
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      rad <= rad << 4;
      rem <= rem_v;
      q <= q_v;
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[sv/qte_datapath.sv]
// Datapath: gain registers, tank levels, roots, shared multiplier, accumulator, output beat.
// Depends on qte_pkg and qte_sqrt; driven by control words from qte_sequencer.
module qte_datapath #(
  parameter int LEVEL_FRAC_BITS = qte_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  qte_pkg::ctl_t ctl,
  output qte_pkg::stat_t stat,
  input  logic [qte_pkg::VOLT_W-1:0] pump1_volts,
  input  logic [qte_pkg::VOLT_W-1:0] pump2_volts,
  input  logic cfg_write,
  input  logic [qte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qte_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic out_stall,
  output logic out_valid,
  output logic [qte_pkg::LEVEL_W-1:0] level_1,
  output logic [qte_pkg::LEVEL_W-1:0] level_2,
  output logic [qte_pkg::LEVEL_W-1:0] level_3,
  output logic [qte_pkg::LEVEL_W-1:0] level_4,
  output logic saturated
);
  import qte_pkg::*;

  localparam int ITER = (LEVEL_W + LEVEL_FRAC_BITS + 3) / 4;
  localparam int ROOT_W = 2 * ITER;
  localparam int PROD_W = GAIN_W + ROOT_W;
  localparam int PUMP_SHIFT = GAIN_FRAC_BITS + VOLT_FRAC_BITS - LEVEL_FRAC_BITS;
  localparam int TERM_W = (ROOT_W + LEVEL_FRAC_BITS > LEVEL_W) ?
                          ROOT_W + LEVEL_FRAC_BITS : LEVEL_W;
  // Three positive terms less one, plus a sign bit.
  localparam int ACC_W = TERM_W + 3;

  logic [GAIN_W-1:0] drain [NUM_TANKS];
  logic [GAIN_W-1:0] cross_31;
  logic [GAIN_W-1:0] cross_42;
  logic [CFG_DATA_W-1:0] pump1_gains;
  logic [CFG_DATA_W-1:0] pump2_gains;
  logic [LEVEL_W-1:0] tank [NUM_TANKS];
  logic [ROOT_W-1:0] roots [NUM_TANKS];
  logic [VOLT_W-1:0] volt1;
  logic [VOLT_W-1:0] volt2;
  logic [PROD_W-1:0] prod;
  logic [ACC_W-1:0] acc;
  logic sat_run;

  logic [GAIN_W-1:0] mul_a;
  logic [ROOT_W-1:0] mul_b;
  logic [ACC_W-1:0] root_term;
  logic [ACC_W-1:0] pump_term;
  logic [LEVEL_W-1:0] settled;
  logic settle_sat;
  logic sq_start;
  logic sq_busy;
  logic [ROOT_W-1:0] sq_root;
  logic fire;

  assign fire = ctl.fire;
  assign sq_start = fire && ctl.uc.sqrt_start;

  qte_sqrt #(
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
  ) u_sqrt (
    .clk(clk),
    .rst(rst),
    .start(sq_start),
    .level(tank[ctl.uc.tank]),
    .busy(sq_busy),
    .root(sq_root)
  );

  assign stat.sqrt_busy = sq_busy;
  assign stat.out_busy = out_valid && out_stall;

  always_comb begin
    unique case (ctl.uc.gain_sel)
      G_DRAIN_1: mul_a = drain[0];
      G_DRAIN_2: mul_a = drain[1];
      G_DRAIN_3: mul_a = drain[2];
      G_DRAIN_4: mul_a = drain[3];
      G_CROSS_31: mul_a = cross_31;
      G_CROSS_42: mul_a = cross_42;
      G_P1_LO: mul_a = pump1_gains[GAIN_W-1:0];
      G_P1_HI: mul_a = pump1_gains[2*GAIN_W-1:GAIN_W];
      G_P2_LO: mul_a = pump2_gains[GAIN_W-1:0];
      G_P2_HI: mul_a = pump2_gains[2*GAIN_W-1:GAIN_W];
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctl.uc.b_sel)
      B_ROOT: mul_b = roots[ctl.uc.b_tank];
      B_VOLT_1: mul_b = ROOT_W'(volt1);
      B_VOLT_2: mul_b = ROOT_W'(volt2);
      default: mul_b = '0;
    endcase
  end

  // Each product is truncated on its own before it enters the sum.
  assign root_term = ACC_W'(prod >> GAIN_FRAC_BITS);
  assign pump_term = ACC_W'(prod >> PUMP_SHIFT);

  always_comb begin
    if (acc[ACC_W-1]) begin
      settled = '0;
      settle_sat = 1'b1;
    end else if (|acc[ACC_W-2:LEVEL_W]) begin
      settled = '1;
      settle_sat = 1'b1;
    end else begin
      settled = acc[LEVEL_W-1:0];
      settle_sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TANKS; i++) begin
        drain[i] <= '0;
      end
      cross_31 <= '0;
      cross_42 <= '0;
      pump1_gains <= '0;
      pump2_gains <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_DRAIN_1: drain[0] <= cfg_data[GAIN_W-1:0];
        REG_DRAIN_2: drain[1] <= cfg_data[GAIN_W-1:0];
        REG_DRAIN_3: drain[2] <= cfg_data[GAIN_W-1:0];
        REG_DRAIN_4: drain[3] <= cfg_data[GAIN_W-1:0];
        REG_CROSS_31: cross_31 <= cfg_data[GAIN_W-1:0];
        REG_CROSS_42: cross_42 <= cfg_data[GAIN_W-1:0];
        REG_PUMP_1: pump1_gains <= cfg_data;
        REG_PUMP_2: pump2_gains <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctl.uc.in_take) begin
      volt1 <= pump1_volts;
      volt2 <= pump2_volts;
    end
    if (fire && ctl.uc.root_wr) begin
      roots[ctl.uc.tank] <= sq_root;
    end
    if (fire && ctl.uc.mul_en) begin
      prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (fire) begin
      unique case (ctl.uc.acc_op)
        ACC_LOAD: acc <= ACC_W'(tank[ctl.uc.tank]);
        ACC_ADD_ROOT: acc <= acc + root_term;
        ACC_ADD_PUMP: acc <= acc + pump_term;
        ACC_SUB_ROOT: acc <= acc - root_term;
        default: acc <= acc;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TANKS; i++) begin
        tank[i] <= '0;
      end
      sat_run <= 1'b0;
    end else if (fire && ctl.uc.in_take) begin
      sat_run <= 1'b0;
    end else if (fire && ctl.uc.acc_op == ACC_SETTLE) begin
      tank[ctl.uc.tank] <= settled;
      sat_run <= sat_run | settle_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && ctl.uc.out_load) begin
      out_valid <= 1'b1;
      level_1 <= tank[0];
      level_2 <= tank[1];
      level_3 <= tank[2];
      level_4 <= tank[3];
      saturated <= sat_run;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[sv/qte_sequencer.sv]
// Microcode sequencer: step counter, program table lookup and conditional advance.
// Depends on qte_pkg for the program and the control word layout.
module qte_sequencer (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  qte_pkg::stat_t stat,
  output qte_pkg::ctl_t ctl
);
  import qte_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t uc;
  logic go;

  assign uc = qte_ucode(pc);

  always_comb begin
    unique case (uc.cond)
      COND_ALWAYS: go = 1'b1;
      COND_IN: go = in_valid;
      COND_SQRT: go = !stat.sqrt_busy;
      COND_OUT: go = !stat.out_busy;
      default: go = 1'b0;
    endcase
  end

  assign in_stall = (uc.cond != COND_IN);
  assign ctl.fire = go;
  assign ctl.uc = uc;
  assign pc_next = go ? uc.next : pc;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[sv/quad_tank_euler_step.sv]
// Top level of the four-tank Euler step: sequencer plus datapath.
// Depends on qte_pkg, qte_sequencer, qte_datapath and qte_sqrt.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | pump1_volts, pump2_volts
//  out     | out_valid / out_stall| level_1..level_4, saturated
//  cfg     | cfg_write            | cfg_index, cfg_data
//
// The four square roots run in turn on the one shared root unit, two root bits
// a cycle, and take up most of each beat.
// Reset clears the gain registers, the tank levels and the output beat.
// A new input beat is taken while the previous result still waits; the block
// only holds in its last step when that result has not yet been taken.
module quad_tank_euler_step #(
  parameter int LEVEL_FRAC_BITS = qte_pkg::LEVEL_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [qte_pkg::VOLT_W-1:0] pump1_volts,
  input  logic [qte_pkg::VOLT_W-1:0] pump2_volts,
  output logic out_valid,
  input  logic out_stall,
  output logic [qte_pkg::LEVEL_W-1:0] level_1,
  output logic [qte_pkg::LEVEL_W-1:0] level_2,
  output logic [qte_pkg::LEVEL_W-1:0] level_3,
  output logic [qte_pkg::LEVEL_W-1:0] level_4,
  output logic saturated,
  input  logic cfg_write,
  input  logic [qte_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [qte_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qte_pkg::*;

  ctl_t ctl;
  stat_t stat;

  qte_sequencer u_seq (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .stat(stat),
    .ctl(ctl)
  );

  qte_datapath #(
    .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .stat(stat),
    .pump1_volts(pump1_volts),
    .pump2_volts(pump2_volts),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .level_1(level_1),
    .level_2(level_2),
    .level_3(level_3),
    .level_4(level_4),
    .saturated(saturated)
  );

endmodule

[tb/sv/quad_tank_euler_step_test.sv]
// Self-checking testbench for quad_tank_euler_step: tank levels predicted in SV, checked per beat.
// Depends on qte_pkg and the quad_tank_euler_step RTL; needs no files or arguments at run time.
module quad_tank_euler_step_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qte_pkg::*;

  localparam int LVL_FRAC = LEVEL_FRAC_BITS_DEF;
  localparam int PUMP_SHIFT = GAIN_FRAC_BITS + VOLT_FRAC_BITS - LVL_FRAC;
  localparam int BEAT_CYCLES = 4 * ((LEVEL_W + LVL_FRAC + 3) / 4) + 28;
  localparam int STUCK_LIMIT = 5000;
  localparam int RAND_PHASES = 6;
  localparam int BEATS_PER_PHASE = 170;

  typedef struct packed {
    logic [VOLT_W-1:0] u1;
    logic [VOLT_W-1:0] u2;
  } pump_beat_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] l1;
    logic [LEVEL_W-1:0] l2;
    logic [LEVEL_W-1:0] l3;
    logic [LEVEL_W-1:0] l4;
    logic sat;
  } level_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [VOLT_W-1:0] pump1_volts = '0;
  logic [VOLT_W-1:0] pump2_volts = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [LEVEL_W-1:0] level_1, level_2, level_3, level_4;
  logic saturated;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pump_beat_t volts_feed_q[$];
  level_beat_t level_exp_q[$];
  logic [LEVEL_W-1:0] tank_lvl[NUM_TANKS];
  logic [CFG_DATA_W-1:0] gain_shadow[8];
  logic [CFG_DATA_W-1:0] next_gains[8];
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int fail_count = 0;
  int beats_taken = 0;
  int beats_checked = 0;
  int sat_beats = 0;
  int settings_used = 0;
  int stuck_cycles = 0;

  quad_tank_euler_step DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pump1_volts(pump1_volts),
    .pump2_volts(pump2_volts),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .level_1(level_1),
    .level_2(level_2),
    .level_3(level_3),
    .level_4(level_4),
    .saturated(saturated),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Gain in Q8.24 times a root in the level format, truncated back to the level format.
  function automatic logic [63:0] scaled_root(input logic [31:0] gain, input logic [31:0] root);
    return (64'(gain) * 64'(root)) >> GAIN_FRAC_BITS;
  endfunction

  function automatic logic [63:0] pump_flow(input logic [31:0] gain, input logic [VOLT_W-1:0] v);
    return (64'(gain) * 64'(v)) >> PUMP_SHIFT;
  endfunction

  // Advances the shadow tank levels by one Euler step and returns the expected beat.
  function automatic level_beat_t step_tanks(input logic [VOLT_W-1:0] v1,
                                             input logic [VOLT_W-1:0] v2);
    logic [31:0] rt[NUM_TANKS];
    logic [63:0] up[NUM_TANKS];
    logic [63:0] down[NUM_TANKS];
    logic [63:0] radicand, trial;
    logic [LEVEL_W-1:0] nxt[NUM_TANKS];
    level_beat_t res;
    logic hit;
    hit = 1'b0;
    for (int t = 0; t < NUM_TANKS; t++) begin
      // Floor root of the level shifted up, so the root lands in the level format.
      radicand = 64'(tank_lvl[t]) << LVL_FRAC;
      rt[t] = '0;
      for (int b = 31; b >= 0; b--) begin
        trial = 64'(rt[t] | (32'd1 << b));
        if (trial * trial <= radicand) rt[t] = trial[31:0];
      end
    end
    up[0] = 64'(tank_lvl[0]) + scaled_root(gain_shadow[REG_CROSS_31][31:0], rt[2])
          + pump_flow(gain_shadow[REG_PUMP_1][31:0], v1);
    up[1] = 64'(tank_lvl[1]) + scaled_root(gain_shadow[REG_CROSS_42][31:0], rt[3])
          + pump_flow(gain_shadow[REG_PUMP_2][31:0], v2);
    up[2] = 64'(tank_lvl[2]) + pump_flow(gain_shadow[REG_PUMP_2][63:32], v2);
    up[3] = 64'(tank_lvl[3]) + pump_flow(gain_shadow[REG_PUMP_1][63:32], v1);
    down[0] = scaled_root(gain_shadow[REG_DRAIN_1][31:0], rt[0]);
    down[1] = scaled_root(gain_shadow[REG_DRAIN_2][31:0], rt[1]);
    down[2] = scaled_root(gain_shadow[REG_DRAIN_3][31:0], rt[2]);
    down[3] = scaled_root(gain_shadow[REG_DRAIN_4][31:0], rt[3]);
    for (int t = 0; t < NUM_TANKS; t++) begin
      if (up[t] < down[t]) begin
        nxt[t] = '0;
        hit = 1'b1;
      end else if (up[t] - down[t] > 64'hFFFF_FFFF) begin
        nxt[t] = '1;
        hit = 1'b1;
      end else begin
        nxt[t] = 32'(up[t] - down[t]);
      end
      tank_lvl[t] = nxt[t];
    end
    res.l1 = nxt[0];
    res.l2 = nxt[1];
    res.l3 = nxt[2];
    res.l4 = nxt[3];
    res.sat = hit;
    return res;
  endfunction

  // Mostly plausible gains, with the two extremes mixed in.
  function automatic logic [31:0] pick_gain();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return $urandom();
      default: return $urandom_range(0, 32'h0040_0000);
    endcase
  endfunction

  function automatic logic [VOLT_W-1:0] pick_volts();
    case ($urandom_range(19))
      0: return '0;
      1: return '1;
      2, 3: return VOLT_W'($urandom());
      default: return VOLT_W'($urandom_range(0, 16'h0C00));
    endcase
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (volts_feed_q.size() != 0 || in_valid || level_exp_q.size() != 0) @(negedge clk);
  endtask

  // Writes all eight registers from next_gains; the 32-bit ones get junk in their upper half.
  task automatic apply_gains();
    logic [CFG_DATA_W-1:0] word;
    for (int i = 0; i < 8; i++) begin
      word = next_gains[i];
      if (i < REG_PUMP_1) word[63:32] = $urandom();
      @(posedge clk);
      cfg_write <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data <= word;
      gain_shadow[i] = (i < REG_PUMP_1) ? {32'd0, word[31:0]} : word;
    end
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  always @(posedge clk) begin : drive
    pump_beat_t nb;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        level_exp_q.push_back(step_tanks(pump1_volts, pump2_volts));
        beats_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (volts_feed_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
          nb = volts_feed_q.pop_front();
          in_valid <= 1'b1;
          pump1_volts <= nb.u1;
          pump2_volts <= nb.u2;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check
    level_beat_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_idle_pct);
      if (out_valid && !out_stall) begin
        if (level_exp_q.size() == 0) begin
          $error("level beat with nothing expected: %h %h %h %h sat %b",
                 level_1, level_2, level_3, level_4, saturated);
          fail_count++;
        end else begin
          want = level_exp_q.pop_front();
          beats_checked++;
          if (saturated === 1'b1) sat_beats++;
          if (level_1 !== want.l1) begin
            $error("level_1: expected %h, actual %h", want.l1, level_1);
            fail_count++;
          end
          if (level_2 !== want.l2) begin
            $error("level_2: expected %h, actual %h", want.l2, level_2);
            fail_count++;
          end
          if (level_3 !== want.l3) begin
            $error("level_3: expected %h, actual %h", want.l3, level_3);
            fail_count++;
          end
          if (level_4 !== want.l4) begin
            $error("level_4: expected %h, actual %h", want.l4, level_4);
            fail_count++;
          end
          if (saturated !== want.sat) begin
            $error("saturated: expected %b, actual %b", want.sat, saturated);
            fail_count++;
          end
        end
      end
    end
  end

  // Any beat on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("No beat moved for %0d cycles.", STUCK_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    pump_beat_t b;
    for (int t = 0; t < NUM_TANKS; t++) tank_lvl[t] = '0;
    for (int i = 0; i < 8; i++) gain_shadow[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    snd_idle_pct = 38;
    rcv_idle_pct = 77;

    // Gains still at their reset value: nothing moves.
    @(negedge clk);
    volts_feed_q.push_back('{u1: '0, u2: '0});
    volts_feed_q.push_back('{u1: '1, u2: '1});
    wait_drained();

    // Moderate gains: fill the tanks, then hit the voltage extremes and bit patterns.
    next_gains[REG_DRAIN_1] = 64'h0010_0000;
    next_gains[REG_DRAIN_2] = 64'h0014_0000;
    next_gains[REG_DRAIN_3] = 64'h000C_0000;
    next_gains[REG_DRAIN_4] = 64'h0008_0000;
    next_gains[REG_CROSS_31] = 64'h0008_0000;
    next_gains[REG_CROSS_42] = 64'h0006_0000;
    next_gains[REG_PUMP_1] = {32'h0004_0000, 32'h0010_0000};
    next_gains[REG_PUMP_2] = {32'h0006_0000, 32'h0012_0000};
    apply_gains();
    @(negedge clk);
    repeat (4) volts_feed_q.push_back('{u1: 16'h0A00, u2: 16'h0A00});
    volts_feed_q.push_back('{u1: '1, u2: '0});
    volts_feed_q.push_back('{u1: '0, u2: '1});
    volts_feed_q.push_back('{u1: 16'hAAAA, u2: 16'h5555});
    volts_feed_q.push_back('{u1: 16'h5555, u2: 16'hAAAA});
    repeat (2) volts_feed_q.push_back('{u1: '0, u2: '0});
    wait_drained();

    // Every gain at full scale: levels clamp at the top, then drain out to zero.
    for (int i = 0; i < 8; i++) next_gains[i] = '1;
    apply_gains();
    @(negedge clk);
    repeat (3) volts_feed_q.push_back('{u1: '1, u2: '1});
    repeat (3) volts_feed_q.push_back('{u1: '0, u2: '0});
    wait_drained();

    // Zero gains written explicitly: levels hold whatever the pumps do.
    for (int i = 0; i < 8; i++) next_gains[i] = '0;
    apply_gains();
    @(negedge clk);
    volts_feed_q.push_back('{u1: 16'h1234, u2: 16'hFEDC});
    volts_feed_q.push_back('{u1: '1, u2: '1});
    wait_drained();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == RAND_PHASES / 3) begin
        snd_idle_pct = 77;
        rcv_idle_pct = 38;
      end else if (ph == 2 * RAND_PHASES / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      for (int i = 0; i < REG_PUMP_1; i++) next_gains[i] = {32'd0, pick_gain()};
      next_gains[REG_PUMP_1] = {pick_gain(), pick_gain()};
      next_gains[REG_PUMP_2] = {pick_gain(), pick_gain()};
      apply_gains();
      @(negedge clk);
      for (int n = 0; n < BEATS_PER_PHASE; n++) begin
        b.u1 = pick_volts();
        b.u2 = pick_volts();
        volts_feed_q.push_back(b);
      end
      wait_drained();
    end

    repeat (2 * BEAT_CYCLES) @(posedge clk);
    $display("Checked %0d of %0d pump beats under %0d gain settings; %0d beats clamped a level.",
             beats_checked, beats_taken, settings_used, sat_beats);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
sv/qte_pkg.sv
sv/qte_sqrt.sv
sv/qte_datapath.sv
sv/qte_sequencer.sv
sv/quad_tank_euler_step.sv
tb/sv/quad_tank_euler_step_test.sv
